FILE: rtl/core/agl_pkg.sv
package agl_pkg;

	// Default store depth
	localparam int unsigned MAX_GLYPHS_DEF = 64;

	// Fit divider operand widths: scale (16b) times numerator (12b), divisor up to total height
	localparam int unsigned DIVD_W = 28;
	localparam int unsigned DIVS_W = 23;
	localparam int unsigned DIV_CNT_W = 5;

	// Alignment codes
	localparam logic [1:0] ALIGN_LEFT  = 2'd0;
	localparam logic [1:0] ALIGN_RIGHT = 2'd1;

	// Register indexes
	typedef enum logic [2:0] {
		REG_ALIGN  = 3'd0,
		REG_FIT    = 3'd1,
		REG_SCX    = 3'd2,
		REG_SCY    = 3'd3,
		REG_LH     = 3'd4,
		REG_BW     = 3'd5,
		REG_BH     = 3'd6,
		REG_CY     = 3'd7
	} cfg_reg_t;

	// Layout sequencer states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_STEP0,
		ST_TOTAL,
		ST_BOX,
		ST_START,
		ST_SRD,
		ST_SCHK,
		ST_SACC,
		ST_CMP1,
		ST_CMP2,
		ST_DEC,
		ST_MX,
		ST_DX,
		ST_WX,
		ST_MY,
		ST_DY,
		ST_WY,
		ST_STEP,
		ST_STEP2,
		ST_ERD,
		ST_EMW,
		ST_EMH,
		ST_EMA,
		ST_EOUT
	} state_t;

	// Divider request
	typedef struct packed {
		logic                start;
		logic [DIVD_W-1:0]   dividend;
		logic [DIVS_W-1:0]   divisor;
	} div_req_t;

endpackage

FILE: rtl/core/agl_div.sv
module agl_div (
	input  logic                clk,
	input  logic                arst_n,
	input  agl_pkg::div_req_t   req,
	output logic                done,
	output logic [15:0]         quotient
);

	logic                          busy_q;
	logic                          done_q;
	logic [agl_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [agl_pkg::DIVS_W:0]      rem_q;
	logic [agl_pkg::DIVD_W-1:0]    quo_q;
	logic [agl_pkg::DIVS_W-1:0]    den_q;
	logic [agl_pkg::DIVS_W:0]      trial;
	logic                          take;

	// Restoring division, one quotient bit per cycle
	assign trial = {rem_q[agl_pkg::DIVS_W-1:0], quo_q[agl_pkg::DIVD_W-1]};
	assign take  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == agl_pkg::DIV_CNT_W'(agl_pkg::DIVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			den_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= take ? (trial - {1'b0, den_q}) : trial;
			quo_q <= {quo_q[agl_pkg::DIVD_W-2:0], take};
		end
	end

	// Saturate to 16 bits
	assign done     = done_q;
	assign quotient = (quo_q[agl_pkg::DIVD_W-1:16] != '0) ? 16'hFFFF : quo_q[15:0];

endmodule

FILE: rtl/core/aligned_glyph_layout.sv
// Aligned glyph layout.
// Input stream s_*: one glyph per request, metrics in s_tdata, newline mark
// in s_tuser, s_tlast on the final glyph of a text. Glyphs load one per cycle
// into a MAX_GLYPHS-entry store; entries past a full store are dropped.
// The request with s_tlast starts the layout pass; s_tready stays low until
// the last rectangle has been placed in the output register.
// Output stream m_*: one rectangle per stored glyph in load order, m_tlast on
// the final one. The output register lets the block go back to loading while
// the last rectangle waits; a stalled m_tready stalls the pass.
// Sequence: setup, then with fitting a scan of the glyphs, the compares, up
// to two divider waits and the line step (only the line step without
// fitting); the emit pass sums each row, then forms its rectangles. All
// products go through one shared 23x16 multiplier.
// Configuration: APB, registers at 4*index, readable. Write only while idle.
// Reset: registers take their defaults, the store is empty.
module aligned_glyph_layout #(
	parameter int unsigned MAX_GLYPHS = agl_pkg::MAX_GLYPHS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Glyph input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // glyph_advance[7:0], glyph_width[15:8], glyph_height[23:16]
	input  logic        s_tuser,  // is_newline
	input  logic        s_tlast,  // last_glyph
	// Rectangle output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // glyph_index[5:0], rect_x[21:6], rect_y[37:22],
	                              // rect_w[53:38], rect_h[69:54], zero[71:70]
	output logic        m_tlast   // last_rect
);

	localparam int unsigned AW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
	localparam int unsigned CW = $clog2(MAX_GLYPHS + 1);

	// Configuration registers
	logic [1:0]  align_q;
	logic        fit_q;
	logic [15:0] scx_q, scy_q, cy_q;
	logic [7:0]  lh_q;
	logic [11:0] bw_q, bh_q;

	// Control
	agl_pkg::state_t state_q, state_d;
	logic [CW-1:0] cnt_q, lc_q, idx_q, rowst_q;
	logic          pass_q;
	logic          ov_q;

	// Datapath
	logic [24:0] mem [MAX_GLYPHS];
	logic [24:0] rd_q;
	logic [22:0] mul_a;
	logic [15:0] mul_b;
	logic [38:0] mul_q;
	logic [15:0] sx_q, sy_q, sty_q, step_q, x_q, y_q, ws_q, hs_q;
	logic [22:0] total_q, den_q;
	logic [19:0] box_q;
	logic [21:0] longest_q, sum_q;
	logic [34:0] p1_q;
	logic [11:0] num_q;
	logic [69:0] od_q;
	logic        ol_q;

	logic        in_acc, cfg_wr, out_free, row_end, is_last, use_h;
	logic [24:0] v2;
	logic [24:0] v2r;
	logic [15:0] adv_s, x_init, rx;
	agl_pkg::div_req_t div_req;
	logic        div_done;
	logic [15:0] div_quo;

	assign in_acc   = s_tvalid && s_tready;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign out_free = !ov_q || m_tready;
	assign row_end  = (idx_q == cnt_q) || rd_q[24];
	assign is_last  = idx_q == (cnt_q - 1'b1);
	assign adv_s    = mul_q[23:8];
	assign use_h    = (total_q != '0) &&
	                  ((longest_q == '0) || (p1_q < mul_q[34:0]));

	assign pready   = 1'b1;
	assign s_tready = state_q == agl_pkg::ST_IDLE;
	assign m_tvalid = ov_q;
	assign m_tdata  = {2'b00, od_q};
	assign m_tlast  = ol_q;

	// Start y, halving truncated toward zero
	assign v2  = {{8{cy_q[15]}}, cy_q, 1'b0} - {2'b00, total_q};
	assign v2r = v2 + {24'd0, v2[24]};

	// Row start x per alignment
	always_comb begin
		case (align_q)
			agl_pkg::ALIGN_LEFT:  x_init = '0;
			agl_pkg::ALIGN_RIGHT: x_init = box_q[15:0] - sum_q[15:0];
			default:              x_init = box_q[16:1] - sum_q[16:1];
		endcase
	end

	assign rx = (align_q == agl_pkg::ALIGN_RIGHT) ? (x_q + adv_s - ws_q) : x_q;

	// Shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			agl_pkg::ST_STEP0: begin mul_a = 23'(lh_q);        mul_b = scy_q; end
			agl_pkg::ST_TOTAL: begin mul_a = 23'(mul_q[23:8]); mul_b = 16'(lc_q + 1'b1); end
			agl_pkg::ST_BOX:   begin mul_a = 23'(bw_q);        mul_b = scx_q; end
			agl_pkg::ST_SCHK:  begin mul_a = 23'(rd_q[7:0]);   mul_b = sx_q; end
			agl_pkg::ST_CMP1:  begin mul_a = 23'(longest_q);   mul_b = 16'(bh_q); end
			agl_pkg::ST_CMP2:  begin mul_a = total_q;          mul_b = 16'(bw_q); end
			agl_pkg::ST_MX:    begin mul_a = 23'(num_q);       mul_b = sx_q; end
			agl_pkg::ST_MY:    begin mul_a = 23'(num_q);       mul_b = sy_q; end
			agl_pkg::ST_STEP:  begin mul_a = 23'(lh_q);        mul_b = sy_q; end
			agl_pkg::ST_EMW:   begin mul_a = 23'(rd_q[15:8]);  mul_b = sx_q; end
			agl_pkg::ST_EMH:   begin mul_a = 23'(rd_q[23:16]); mul_b = sy_q; end
			agl_pkg::ST_EMA:   begin mul_a = 23'(rd_q[7:0]);   mul_b = sx_q; end
			// keep the scaled advance while the output stalls
			agl_pkg::ST_EOUT:  begin mul_a = 23'(rd_q[7:0]);   mul_b = sx_q; end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= {16'd0, mul_a} * {23'd0, mul_b};
	end

	// Glyph store
	always_ff @(posedge clk) begin
		if (in_acc && (cnt_q < CW'(MAX_GLYPHS)))
			mem[cnt_q[AW-1:0]] <= {s_tuser, s_tdata};
		rd_q <= mem[idx_q[AW-1:0]];
	end

	// Divider request
	always_comb begin
		div_req.start    = (state_q == agl_pkg::ST_DX) || (state_q == agl_pkg::ST_DY);
		div_req.dividend = mul_q[27:0];
		div_req.divisor  = den_q;
	end

	agl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			align_q <= 2'd2;
			fit_q   <= 1'b1;
			scx_q   <= 16'd256;
			scy_q   <= 16'd256;
			lh_q    <= 8'd16;
			bw_q    <= '0;
			bh_q    <= '0;
			cy_q    <= '0;
		end else if (cfg_wr) begin
			unique case (agl_pkg::cfg_reg_t'(paddr[4:2]))
				agl_pkg::REG_ALIGN: align_q <= pwdata[1:0];
				agl_pkg::REG_FIT:   fit_q   <= pwdata[0];
				agl_pkg::REG_SCX:   scx_q   <= pwdata[15:0];
				agl_pkg::REG_SCY:   scy_q   <= pwdata[15:0];
				agl_pkg::REG_LH:    lh_q    <= pwdata[7:0];
				agl_pkg::REG_BW:    bw_q    <= pwdata[11:0];
				agl_pkg::REG_BH:    bh_q    <= pwdata[11:0];
				agl_pkg::REG_CY:    cy_q    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		unique case (agl_pkg::cfg_reg_t'(paddr[4:2]))
			agl_pkg::REG_ALIGN: prdata = 32'(align_q);
			agl_pkg::REG_FIT:   prdata = 32'(fit_q);
			agl_pkg::REG_SCX:   prdata = 32'(scx_q);
			agl_pkg::REG_SCY:   prdata = 32'(scy_q);
			agl_pkg::REG_LH:    prdata = 32'(lh_q);
			agl_pkg::REG_BW:    prdata = 32'(bw_q);
			agl_pkg::REG_BH:    prdata = 32'(bh_q);
			agl_pkg::REG_CY:    prdata = 32'(cy_q);
			default:            prdata = '0;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			agl_pkg::ST_IDLE:  if (in_acc && s_tlast) state_d = agl_pkg::ST_STEP0;
			agl_pkg::ST_STEP0: state_d = agl_pkg::ST_TOTAL;
			agl_pkg::ST_TOTAL: state_d = agl_pkg::ST_BOX;
			agl_pkg::ST_BOX:   state_d = agl_pkg::ST_START;
			agl_pkg::ST_START: state_d = fit_q ? agl_pkg::ST_SRD : agl_pkg::ST_STEP;
			agl_pkg::ST_SRD:   state_d = agl_pkg::ST_SCHK;
			agl_pkg::ST_SCHK: begin
				if (!row_end)
					state_d = agl_pkg::ST_SACC;
				else if (pass_q)
					state_d = agl_pkg::ST_ERD;
				else if (idx_q == cnt_q)
					state_d = agl_pkg::ST_CMP1;
				else
					state_d = agl_pkg::ST_SRD;
			end
			agl_pkg::ST_SACC:  state_d = agl_pkg::ST_SRD;
			agl_pkg::ST_CMP1:  state_d = agl_pkg::ST_CMP2;
			agl_pkg::ST_CMP2:  state_d = agl_pkg::ST_DEC;
			agl_pkg::ST_DEC: begin
				if (use_h || (longest_q != '0))
					state_d = agl_pkg::ST_MX;
				else
					state_d = agl_pkg::ST_STEP;
			end
			agl_pkg::ST_MX:    state_d = agl_pkg::ST_DX;
			agl_pkg::ST_DX:    state_d = agl_pkg::ST_WX;
			agl_pkg::ST_WX:    if (div_done) state_d = agl_pkg::ST_MY;
			agl_pkg::ST_MY:    state_d = agl_pkg::ST_DY;
			agl_pkg::ST_DY:    state_d = agl_pkg::ST_WY;
			agl_pkg::ST_WY:    if (div_done) state_d = agl_pkg::ST_STEP;
			agl_pkg::ST_STEP:  state_d = agl_pkg::ST_STEP2;
			agl_pkg::ST_STEP2: state_d = agl_pkg::ST_SRD;
			agl_pkg::ST_ERD:   state_d = agl_pkg::ST_EMW;
			agl_pkg::ST_EMW:   state_d = rd_q[24] ? agl_pkg::ST_EOUT : agl_pkg::ST_EMH;
			agl_pkg::ST_EMH:   state_d = agl_pkg::ST_EMA;
			agl_pkg::ST_EMA:   state_d = agl_pkg::ST_EOUT;
			agl_pkg::ST_EOUT: begin
				if (out_free) begin
					if (is_last)
						state_d = agl_pkg::ST_IDLE;
					else if (rd_q[24])
						state_d = agl_pkg::ST_SRD;
					else
						state_d = agl_pkg::ST_ERD;
				end
			end
			default: state_d = agl_pkg::ST_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= agl_pkg::ST_IDLE;
			cnt_q   <= '0;
			lc_q    <= '0;
			idx_q   <= '0;
			rowst_q <= '0;
			pass_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == agl_pkg::ST_EOUT) && out_free)
				ov_q <= 1'b1;
			else if (ov_q && m_tready)
				ov_q <= 1'b0;
			case (state_q)
				agl_pkg::ST_IDLE: begin
					if (in_acc && (cnt_q < CW'(MAX_GLYPHS))) begin
						cnt_q <= cnt_q + 1'b1;
						if (s_tuser)
							lc_q <= lc_q + 1'b1;
					end
					idx_q  <= '0;
					pass_q <= 1'b0;
				end
				agl_pkg::ST_SCHK: begin
					if (row_end && pass_q)
						idx_q <= rowst_q;
					else if (row_end && (idx_q != cnt_q))
						idx_q <= idx_q + 1'b1;
				end
				agl_pkg::ST_SACC: idx_q <= idx_q + 1'b1;
				agl_pkg::ST_STEP2: begin
					idx_q   <= '0;
					rowst_q <= '0;
					pass_q  <= 1'b1;
				end
				agl_pkg::ST_EOUT: begin
					if (out_free) begin
						if (is_last) begin
							cnt_q <= '0;
							lc_q  <= '0;
						end else begin
							idx_q <= idx_q + 1'b1;
							if (rd_q[24])
								rowst_q <= idx_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			agl_pkg::ST_STEP0: begin
				sx_q <= scx_q;
				sy_q <= scy_q;
			end
			agl_pkg::ST_BOX:   total_q <= mul_q[22:0];
			agl_pkg::ST_START: begin
				box_q     <= mul_q[27:8];
				sty_q     <= v2r[16:1];
				longest_q <= '0;
				sum_q     <= '0;
			end
			agl_pkg::ST_SCHK: begin
				if (row_end && !pass_q) begin
					if (sum_q > longest_q)
						longest_q <= sum_q;
					sum_q <= '0;
				end
				if (row_end && pass_q)
					x_q <= x_init;
			end
			agl_pkg::ST_SACC:  sum_q <= sum_q + 22'(mul_q[23:8]);
			agl_pkg::ST_CMP2:  p1_q <= mul_q[34:0];
			agl_pkg::ST_DEC: begin
				if (use_h) begin
					num_q <= bh_q;
					den_q <= total_q;
				end else begin
					num_q <= bw_q;
					den_q <= 23'(longest_q);
				end
			end
			agl_pkg::ST_WX:    if (div_done) sx_q <= div_quo;
			agl_pkg::ST_WY:    if (div_done) sy_q <= div_quo;
			agl_pkg::ST_STEP2: begin
				step_q <= mul_q[23:8];
				y_q    <= sty_q;
				sum_q  <= '0;
			end
			agl_pkg::ST_EMW: begin
				ws_q <= '0;
				hs_q <= '0;
			end
			agl_pkg::ST_EMH:   ws_q <= mul_q[23:8];
			agl_pkg::ST_EMA:   hs_q <= mul_q[23:8];
			agl_pkg::ST_EOUT: begin
				if (out_free) begin
					ol_q <= is_last;
					if (rd_q[24]) begin
						od_q  <= {64'd0, 6'(idx_q)};
						y_q   <= y_q + step_q;
						sum_q <= '0;
					end else begin
						od_q <= {hs_q, ws_q, y_q, rx, 6'(idx_q)};
						x_q  <= x_q + adv_s;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: dv/aligned_glyph_layout_test.sv
`timescale 1ns / 1ps

module aligned_glyph_layout_test;

	localparam int unsigned STORE_DEPTH = 64;
	localparam logic [1:0] ALIGN_CENTRE = 2'd2;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic        m_tlast;

	typedef struct packed {
		logic [5:0]  index;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] w;
		logic [15:0] h;
		logic        last;
	} rect_t;

	// shadow of the layout registers
	logic [1:0]  cfg_align;
	logic        cfg_fit;
	logic [15:0] cfg_scx;
	logic [15:0] cfg_scy;
	logic [7:0]  cfg_lh;
	logic [11:0] cfg_bw;
	logic [11:0] cfg_bh;
	logic [15:0] cfg_cy;

	// shadow of the glyph store
	logic [7:0] st_adv [STORE_DEPTH];
	logic [7:0] st_w [STORE_DEPTH];
	logic [7:0] st_h [STORE_DEPTH];
	logic       st_nl [STORE_DEPTH];
	int         st_count;
	int         st_lines;

	rect_t pending_rects[$];
	int    errors;
	int    sent;
	int    rects_seen;
	int    texts;
	int    send_idle_pct;
	int    recv_idle_pct;
	int    hold_cycles;

	aligned_glyph_layout dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("Test completed with failures");
		$finish;
	end

	function automatic longint unsigned scale_q88(longint unsigned v, longint unsigned s);
		return (v * s) >> 8;
	endfunction

	function automatic longint unsigned fitted(longint unsigned s, longint unsigned num,
			longint unsigned den);
		longint unsigned r;
		r = s * num / den;
		return (r > 64'hFFFF) ? 64'hFFFF : r;
	endfunction

	function automatic int row_stop(int from);
		while (from < st_count && !st_nl[from])
			from++;
		return from;
	endfunction

	function automatic longint unsigned row_width(int from, int to, longint unsigned sx);
		longint unsigned sum;
		sum = 0;
		for (int i = from; i < to; i++)
			sum += scale_q88(st_adv[i], sx);
		return sum;
	endfunction

	// compute the rectangles of the stored text and queue them
	task automatic place_text();
		longint lx [STORE_DEPTH];
		longint ly [STORE_DEPTH];
		longint unsigned lw [STORE_DEPTH];
		longint unsigned lh [STORE_DEPTH];
		longint unsigned sx, sy, total, box_w, longest, num, den, s;
		longint v2, start_y, step, x, y, anchor;
		bit have;
		int pos, e, k;
		rect_t r;
		sx = cfg_scx;
		sy = cfg_scy;
		total = scale_q88(cfg_lh, cfg_scy) * (st_lines + 1);
		v2 = 2 * longint'($signed(cfg_cy)) - longint'(total);
		start_y = (v2 >= 0) ? (v2 >>> 1) : -((-v2) >>> 1);
		box_w = scale_q88(cfg_bw, cfg_scx);
		for (int i = 0; i < STORE_DEPTH; i++) begin
			lx[i] = 0; ly[i] = 0; lw[i] = 0; lh[i] = 0;
		end
		if (cfg_fit) begin
			longest = 0; num = 0; den = 0; have = 0; pos = 0;
			forever begin
				e = row_stop(pos);
				s = row_width(pos, e, cfg_scx);
				if (s > longest) longest = s;
				if (e >= st_count) break;
				pos = e + 1;
			end
			if (longest != 0) begin
				num = cfg_bw; den = longest; have = 1;
			end
			if (total != 0 && (!have || longint'(cfg_bh) * den < num * total)) begin
				num = cfg_bh; den = total; have = 1;
			end
			if (have) begin
				sx = fitted(cfg_scx, num, den);
				sy = fitted(cfg_scy, num, den);
			end
		end
		step = scale_q88(cfg_lh, sy);
		if (cfg_align == agl_pkg::ALIGN_LEFT) begin
			x = 0; y = start_y;
			for (int i = 0; i < st_count; i++) begin
				if (st_nl[i]) begin
					x = 0; y += step;
				end else begin
					lx[i] = x; ly[i] = y;
					lw[i] = scale_q88(st_w[i], sx);
					lh[i] = scale_q88(st_h[i], sy);
					x += scale_q88(st_adv[i], sx);
				end
			end
		end else if (cfg_align == agl_pkg::ALIGN_RIGHT) begin
			x = box_w; y = start_y + step * st_lines;
			for (int i = st_count; i > 0; i--) begin
				k = i - 1;
				if (st_nl[k]) begin
					x = box_w; y -= step;
				end else begin
					lw[k] = scale_q88(st_w[k], sx);
					lh[k] = scale_q88(st_h[k], sy);
					lx[k] = x - longint'(lw[k]); ly[k] = y;
					x -= scale_q88(st_adv[k], sx);
				end
			end
		end else begin
			anchor = box_w / 2; y = start_y; pos = 0;
			forever begin
				e = row_stop(pos);
				x = anchor - longint'(row_width(pos, e, sx) / 2);
				for (int i = pos; i < e; i++) begin
					lx[i] = x; ly[i] = y;
					lw[i] = scale_q88(st_w[i], sx);
					lh[i] = scale_q88(st_h[i], sy);
					x += scale_q88(st_adv[i], sx);
				end
				y += step;
				if (e >= st_count) break;
				pos = e + 1;
			end
		end
		for (int i = 0; i < st_count; i++) begin
			r.index = i[5:0];
			r.x = lx[i][15:0];
			r.y = ly[i][15:0];
			r.w = lw[i][15:0];
			r.h = lh[i][15:0];
			r.last = (i + 1 == st_count);
			pending_rects.push_back(r);
		end
		st_count = 0;
		st_lines = 0;
		texts++;
	endtask

	// fold an accepted glyph into the shadow store
	task automatic load_glyph(logic [7:0] adv, logic [7:0] w, logic [7:0] h,
			logic nl, logic last);
		if (st_count < STORE_DEPTH) begin
			st_adv[st_count] = adv;
			st_w[st_count] = w;
			st_h[st_count] = h;
			st_nl[st_count] = nl;
			if (nl) st_lines++;
			st_count++;
		end
		if (last) place_text();
	endtask

	// one request on the glyph stream
	task automatic send_glyph(logic [7:0] adv, logic [7:0] w, logic [7:0] h,
			logic nl, logic last);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
			@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = {h, w, adv};
		s_tuser = nl;
		s_tlast = last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		load_glyph(adv, w, h, nl, last);
		sent++;
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic write_reg(agl_pkg::cfg_reg_t idx, logic [31:0] val);
		psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
		paddr = {idx, 2'b00}; pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			agl_pkg::REG_ALIGN: cfg_align = val[1:0];
			agl_pkg::REG_FIT:   cfg_fit = val[0];
			agl_pkg::REG_SCX:   cfg_scx = val[15:0];
			agl_pkg::REG_SCY:   cfg_scy = val[15:0];
			agl_pkg::REG_LH:    cfg_lh = val[7:0];
			agl_pkg::REG_BW:    cfg_bw = val[11:0];
			agl_pkg::REG_BH:    cfg_bh = val[11:0];
			agl_pkg::REG_CY:    cfg_cy = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
	endtask

	// wait for all rectangles, then let the pass wind down
	task automatic drain();
		while (pending_rects.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_layout(logic [1:0] al, logic fit, logic [15:0] scx, logic [15:0] scy,
			logic [7:0] lh, logic [11:0] bw, logic [11:0] bh, logic [15:0] cy);
		drain();
		write_reg(agl_pkg::REG_ALIGN, 32'(al));
		write_reg(agl_pkg::REG_FIT, 32'(fit));
		write_reg(agl_pkg::REG_SCX, 32'(scx));
		write_reg(agl_pkg::REG_SCY, 32'(scy));
		write_reg(agl_pkg::REG_LH, 32'(lh));
		write_reg(agl_pkg::REG_BW, 32'(bw));
		write_reg(agl_pkg::REG_BH, 32'(bh));
		write_reg(agl_pkg::REG_CY, 32'(cy));
	endtask

	// random text: mostly short lines of glyphs, a newline now and then
	task automatic send_text(int len, int nl_pct);
		for (int i = 0; i < len; i++)
			send_glyph(8'($urandom), 8'($urandom), 8'($urandom),
				$urandom_range(99) < nl_pct, i == len - 1);
	endtask

	task automatic random_layout();
		set_layout(2'($urandom_range(3)), 1'($urandom_range(1)),
			16'($urandom_range(1023)), 16'($urandom_range(1023)), 8'($urandom),
			12'($urandom), 12'($urandom), 16'($urandom));
	endtask

	// result checker
	always @(posedge clk) begin
		rect_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[5:0], m_tdata[21:6], m_tdata[37:22], m_tdata[53:38],
				m_tdata[69:54], m_tlast};
			rects_seen++;
			if (pending_rects.size() == 0) begin
				$display("%0t: unexpected rectangle %h", $time, got);
				errors++;
			end else begin
				want = pending_rects.pop_front();
				if (got !== want) begin
					$display("%0t: rect mismatch exp idx=%0d x=%h y=%h w=%h h=%h last=%b",
						$time, want.index, want.x, want.y, want.w, want.h, want.last);
					$display("%0t:               got idx=%0d x=%h y=%h w=%h h=%h last=%b",
						$time, got.index, got.x, got.y, got.w, got.h, got.last);
					errors++;
				end
			end
		end
	end

	// output backpressure, with an optional long hold-off
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic test_defaults();
		// reset state: centre, fit on, zero bounds so the fitted scales drop to zero
		send_glyph(8'd10, 8'd8, 8'd12, 1'b0, 1'b0);
		send_glyph(8'd0, 8'd0, 8'd0, 1'b1, 1'b0);
		send_glyph(8'd255, 8'd255, 8'd255, 1'b0, 1'b1);
	endtask

	task automatic test_alignments();
		for (int al = 0; al < 4; al++) begin
			set_layout(al[1:0], 1'b0, 16'd256, 16'd512, 8'd20, 12'd300, 12'd100, 16'h8000);
			send_glyph(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
			send_glyph(8'd7, 8'd3, 8'd9, 1'b1, 1'b0);
			send_glyph(8'd1, 8'd2, 8'd0, 1'b0, 1'b0);
			send_glyph(8'd30, 8'd40, 8'd50, 1'b0, 1'b1);
		end
		// lone newline text
		send_glyph(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1);
	endtask

	task automatic test_fit_cases();
		// width-bound fit, height-bound fit, saturating growth, zero divisors
		set_layout(agl_pkg::ALIGN_LEFT, 1'b1, 16'd256, 16'd256, 8'd16, 12'd50, 12'd4095,
			16'h7FFF);
		send_text(6, 20);
		set_layout(agl_pkg::ALIGN_RIGHT, 1'b1, 16'd256, 16'd256, 8'd255, 12'd4095, 12'd10,
			16'd0);
		send_text(5, 40);
		set_layout(ALIGN_CENTRE, 1'b1, 16'hFFFF, 16'hFFFF, 8'd1, 12'd4095, 12'd4095, 16'd0);
		send_glyph(8'd1, 8'd1, 8'd1, 1'b0, 1'b1);
		set_layout(ALIGN_CENTRE, 1'b1, 16'd0, 16'd0, 8'd0, 12'd0, 12'd0, 16'd0);
		send_text(4, 30);
	endtask

	task automatic test_full_store();
		// 70 glyphs: the store keeps 64, the rest are dropped
		set_layout(agl_pkg::ALIGN_LEFT, 1'b0, 16'd128, 16'd128, 8'd8, 12'd100, 12'd100,
			16'd100);
		send_text(70, 8);
	endtask

	task automatic test_random(int target);
		while (sent < target) begin
			if ($urandom_range(3) == 0) random_layout();
			send_text($urandom_range(1, 12), $urandom_range(0, 25));
		end
	endtask

	task automatic test_backpressure();
		// long output stall while the sender keeps offering a text
		drain();
		recv_idle_pct = 0;
		send_idle_pct = 0;
		fork
			hold_cycles = 3000;
			begin
				send_text(40, 10);
				send_text(10, 10);
			end
		join
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0; s_tlast = 1'b0;
		m_tready = 1'b0;
		hold_cycles = 0;
		errors = 0; sent = 0; rects_seen = 0; texts = 0;
		st_count = 0; st_lines = 0;
		cfg_align = ALIGN_CENTRE; cfg_fit = 1'b1; cfg_scx = 16'd256; cfg_scy = 16'd256;
		cfg_lh = 8'd16; cfg_bw = '0; cfg_bh = '0; cfg_cy = '0;
		send_idle_pct = 33;
		recv_idle_pct = 80;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_defaults();
		test_alignments();
		test_fit_cases();
		test_full_store();
		test_random(120);
		drain();
		send_idle_pct = 80;
		recv_idle_pct = 33;
		test_random(180);
		test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(270);
		drain();

		$display("Sent %0d glyphs in %0d texts, checked %0d rectangles.",
			sent, texts, rects_seen);
		$display("Covered all alignments, fit bounds, saturation, full store and stalls.");
		if (errors == 0 && pending_rects.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
